// File: design/reserved_range_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Reserved range table unit: assertion macros
// Concurrent assertion helpers clocked by aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RESERVED_RANGE_TABLE_UNIT_DEFINES_SVH
`define RESERVED_RANGE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define RRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("reserved range table: same-cycle check failed");
`define RRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("reserved range table: next-cycle check failed");
`else
`define RRT_ASSERT_NOW(label, ante, cons)
`define RRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/rrt_pkg.sv
// ----------------------------------------------------------------------------
// Reserved range table package
// Word types, action and status codes shared by the table modules.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int ADDR_W = 48;
    localparam int HID_W  = 8;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = {1'b1, {(ADDR_W-1){1'b0}}};

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [HID_W-1:0]  hid_t;

    typedef enum logic [1:0] {
        ACT_REGISTER = 2'd0,
        ACT_CONTAINS = 2'd1,
        ACT_OVERLAP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        action_t action;
        logic    name_given;
        hid_t    handler_id;
        addr_t   range_start;
        addr_t   range_end;
        addr_t   probe_addr;
    } rrt_req_t;

    typedef struct packed {
        status_t status;
        logic    hit;
    } rrt_rsp_t;

    typedef struct packed {
        logic free;
        logic dup;
        logic contains;
        logic overlaps;
    } rrt_match_t;

endpackage

// File: design/rrt_entry.sv
// ----------------------------------------------------------------------------
// Reserved range table entry
// One table slot: handler id and reserved range, with its comparators.
// ----------------------------------------------------------------------------
module rrt_entry
    import rrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  rrt_req_t   req,
    output rrt_match_t match
);

    hid_t  handler_reg;
    addr_t start_reg;
    addr_t end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            handler_reg <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
        end else if (wr_en) begin
            handler_reg <= req.handler_id;
            start_reg   <= req.range_start;
            end_reg     <= req.range_end;
        end
    end

    logic has_range;
    logic hid_zero;

    always_comb begin
        has_range      = (end_reg != '0);
        hid_zero       = (req.handler_id == '0);
        match.free     = (handler_reg == '0) && !has_range;
        match.dup      = (!hid_zero && (handler_reg == req.handler_id))
                      || (hid_zero && (handler_reg == '0)
                          && (start_reg == req.range_start)
                          && (end_reg == req.range_end));
        match.contains = has_range && (req.probe_addr >= start_reg)
                      && (req.probe_addr < end_reg);
        match.overlaps = has_range && (req.range_start < end_reg)
                      && (req.range_end > start_reg);
    end

endmodule

// File: design/reserved_range_table_unit.sv
// ----------------------------------------------------------------------------
// Reserved range table unit
// Table of handler ids and reserved address ranges with register, contains
// and overlap requests.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_ channel and each produces one result
// word on the m_ channel, in order. A word is held in an input register and
// is resolved against all entries in parallel once the result register can
// take its result. The block takes one word per cycle while the receiver
// does not stall; the single input register and the single result register
// set that figure. When the receiver stalls, the result register holds its
// word, the input register takes one more word and s_ready drops. The task
// limit is to be written through cfg_wen and cfg_wdata only while the block
// is idle, which the block does not enforce. Synchronous reset empties both
// registers and the table; the limit goes to its default, two to the 47th.
// ----------------------------------------------------------------------------
`include "reserved_range_table_unit_defines.svh"

module reserved_range_table_unit
    import rrt_pkg::*;
#(
    parameter int NUM_ENTRIES = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rrt_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rrt_rsp_t m_data,
    input  logic     cfg_wen,
    input  addr_t    cfg_wdata
);

    logic     in_valid_reg;
    logic     in_valid_next;
    rrt_req_t in_req_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    rrt_rsp_t out_rsp_reg;
    rrt_rsp_t out_rsp_next;
    addr_t    limit_reg;

    logic proc_fire;
    logic s_fire;

    rrt_match_t                 match_arr [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]     free_vec;
    logic [NUM_ENTRIES-1:0]     dup_vec;
    logic [NUM_ENTRIES-1:0]     cont_vec;
    logic [NUM_ENTRIES-1:0]     ovl_vec;
    logic [NUM_ENTRIES-1:0]     first_free;
    logic [NUM_ENTRIES-1:0]     wr_vec;
    logic                       taken;
    logic                       s_zero;
    logic                       e_zero;
    logic                       reg_invalid;
    logic                       reg_write;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_rsp_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= s_data;
        end
        if (proc_fire) begin
            out_rsp_reg <= out_rsp_next;
        end
    end

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_entry
        rrt_entry u_entry (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_vec[g]),
            .req     (in_req_reg),
            .match   (match_arr[g])
        );
    end

    always_comb begin
        taken = 1'b0;
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            free_vec[k]   = match_arr[k].free;
            dup_vec[k]    = match_arr[k].dup;
            cont_vec[k]   = match_arr[k].contains;
            ovl_vec[k]    = match_arr[k].overlaps;
            first_free[k] = match_arr[k].free && !taken;
            taken         = taken || match_arr[k].free;
        end
    end

    always_comb begin
        s_zero      = (in_req_reg.range_start == '0);
        e_zero      = (in_req_reg.range_end == '0);
        reg_invalid = !in_req_reg.name_given
                   || (s_zero != e_zero)
                   || (!s_zero && ((in_req_reg.range_start >= in_req_reg.range_end)
                                   || (in_req_reg.range_end > limit_reg)))
                   || ((in_req_reg.handler_id == '0) && s_zero);
        reg_write   = proc_fire && (in_req_reg.action == ACT_REGISTER)
                   && !reg_invalid && !(|dup_vec);
        wr_vec      = reg_write ? first_free : '0;
    end

    always_comb begin
        out_rsp_next.hit = 1'b0;
        unique case (in_req_reg.action)
            ACT_REGISTER: begin
                priority if (reg_invalid) begin
                    out_rsp_next.status = ST_INVALID;
                end else if (|dup_vec) begin
                    out_rsp_next.status = ST_OK;
                end else if (|free_vec) begin
                    out_rsp_next.status = ST_OK;
                end else begin
                    out_rsp_next.status = ST_FULL;
                end
            end
            ACT_CONTAINS: begin
                out_rsp_next.status = ST_OK;
                out_rsp_next.hit    = |cont_vec;
            end
            ACT_OVERLAP: begin
                out_rsp_next.status = ST_OK;
                out_rsp_next.hit    = (in_req_reg.range_start < in_req_reg.range_end)
                                   && (|ovl_vec);
            end
            default: begin
                out_rsp_next.status = ST_INVALID;
            end
        endcase
    end

    `RRT_ASSERT_NOW(a_one_slot_written, 1'b1, $onehot0(wr_vec))
    `RRT_ASSERT_NOW(a_write_ok, |wr_vec, reg_write && out_rsp_next.status == ST_OK)
    `RRT_ASSERT_NOW(a_full_no_slot, proc_fire && out_rsp_next.status == ST_FULL, free_vec == '0)
    `RRT_ASSERT_NEXT(a_result_loaded, proc_fire, out_valid_reg)

endmodule

// File: tb/sv/tb_reserved_range_table_unit.sv
// ----------------------------------------------------------------------------
// Reserved range table unit testbench
// Drives register, contains and overlap words through the valid/ready
// channels and checks every result word against a behavioral table model
// or a fixed answer from the directed table, which covers the validation
// errors, duplicates, the full table and the unused action code. Random
// words follow under several task limits and idling patterns.
// ----------------------------------------------------------------------------
module tb_reserved_range_table_unit
    import rrt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int      TABLE_DEPTH    = 4;
    localparam int      DIR_ROWS       = 26;
    localparam int      PHASE_WORDS    = 160;
    localparam int      DRAIN_CYCLES   = 4;
    localparam int      WATCHDOG_LIMIT = 5000;
    localparam addr_t   ADDR_MAX       = '1;
    localparam action_t ACT_UNUSED     = action_t'(2'd3);

    typedef struct {
        rrt_req_t word;
        bit       known;
        rrt_rsp_t rsp;
    } step_row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rrt_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    rrt_rsp_t m_data;
    logic     cfg_wen;
    addr_t    cfg_wdata;

    hid_t  slot_hid [TABLE_DEPTH];
    addr_t slot_lo  [TABLE_DEPTH];
    addr_t slot_hi  [TABLE_DEPTH];
    addr_t limit_shadow;

    rrt_rsp_t  pending_rsp_q [$];
    step_row_t fixed_answer_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles;
    int n_errors;
    int n_words;
    int n_results;
    int n_hits;
    int n_invalid;
    int n_full;
    int n_settings;

    step_row_t directed_rows [DIR_ROWS] = '{
        '{'{ACT_CONTAINS, 1'b1, 8'h00, 48'h0, 48'h0, 48'h0}, 1'b1, '{ST_OK, 1'b0}},
        '{'{ACT_OVERLAP, 1'b1, 8'h00, 48'h0, ADDR_MAX, ADDR_MAX}, 1'b1, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b0, 8'h05, 48'h1000, 48'h2000, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h05, 48'h1000, 48'h0, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h05, 48'h0, 48'h2000, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h05, 48'h2000, 48'h1000, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h05, 48'h3000, 48'h3000, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h05, 48'h1, LIMIT_RESET + 48'd1, 48'h0}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h00, 48'h0, 48'h0, ADDR_MAX}, 1'b1,
          '{ST_INVALID, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'hFF, 48'h0, 48'h0, 48'h0}, 1'b1, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h00, 48'h1000, 48'h2000, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'hFF, 48'h4000, 48'h5000, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h00, 48'h1000, 48'h2000, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h01, 48'h1, LIMIT_RESET, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_CONTAINS, 1'b1, 8'h00, 48'h0, 48'h0, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_CONTAINS, 1'b1, 8'h00, 48'h0, 48'h0, 48'h1FFF}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_CONTAINS, 1'b1, 8'h00, 48'h0, 48'h0, LIMIT_RESET}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_CONTAINS, 1'b1, 8'h00, 48'h0, 48'h0, ADDR_MAX}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_OVERLAP, 1'b1, 8'h00, 48'h2000, 48'h2000, 48'h0}, 1'b1, '{ST_OK, 1'b0}},
        '{'{ACT_OVERLAP, 1'b1, 8'h00, 48'h2000, 48'h1000, 48'h0}, 1'b1, '{ST_OK, 1'b0}},
        '{'{ACT_OVERLAP, 1'b1, 8'h00, LIMIT_RESET, ADDR_MAX, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_OVERLAP, 1'b1, 8'h00, 48'h0, 48'h1, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h02, 48'h5000, 48'h6000, 48'h0}, 1'b0, '{ST_OK, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h03, 48'h0, 48'h0, 48'h0}, 1'b1, '{ST_FULL, 1'b0}},
        '{'{ACT_REGISTER, 1'b1, 8'h00, 48'h7000, 48'h8000, 48'h0}, 1'b1,
          '{ST_FULL, 1'b0}},
        '{'{ACT_UNUSED, 1'b1, 8'hAA, 48'h1000, 48'h2000, 48'h1800}, 1'b1,
          '{ST_INVALID, 1'b0}}
    };

    reserved_range_table_unit #(
        .NUM_ENTRIES (TABLE_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic status_t try_register(logic named, hid_t hid, addr_t lo, addr_t hi);
        int k;
        if (!named) return ST_INVALID;
        if ((lo == '0) != (hi == '0)) return ST_INVALID;
        if (lo != '0 && (lo >= hi || hi > limit_shadow)) return ST_INVALID;
        if (hid == '0 && lo == '0) return ST_INVALID;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (hid != '0 && slot_hid[k] == hid) return ST_OK;
            if (hid == '0 && slot_hid[k] == '0 && slot_lo[k] == lo && slot_hi[k] == hi)
                return ST_OK;
        end
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (slot_hid[k] == '0 && slot_hi[k] == '0) begin
                slot_hid[k] = hid;
                slot_lo[k]  = lo;
                slot_hi[k]  = hi;
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    function automatic rrt_rsp_t resolve_request(rrt_req_t w);
        rrt_rsp_t r;
        int       k;
        r.status = ST_INVALID;
        r.hit    = 1'b0;
        case (w.action)
            ACT_REGISTER: begin
                r.status = try_register(w.name_given, w.handler_id, w.range_start,
                                        w.range_end);
            end
            ACT_CONTAINS: begin
                r.status = ST_OK;
                for (k = 0; k < TABLE_DEPTH; k++)
                    if (slot_hi[k] != '0 && w.probe_addr >= slot_lo[k] &&
                        w.probe_addr < slot_hi[k])
                        r.hit = 1'b1;
            end
            ACT_OVERLAP: begin
                r.status = ST_OK;
                if (w.range_start < w.range_end)
                    for (k = 0; k < TABLE_DEPTH; k++)
                        if (slot_hi[k] != '0 && w.range_start < slot_hi[k] &&
                            w.range_end > slot_lo[k])
                            r.hit = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic addr_t rand_addr();
        return addr_t'({$urandom, $urandom});
    endfunction

    function automatic addr_t near_addr();
        int    k;
        addr_t lo;
        addr_t hi;
        k  = $urandom_range(TABLE_DEPTH - 1);
        lo = slot_lo[k];
        hi = slot_hi[k];
        case ($urandom_range(8))
            0: return lo - 48'd1;
            1: return lo;
            2: return hi - 48'd1;
            3: return hi;
            4: return (hi > lo) ? lo + rand_addr() % (hi - lo) : lo;
            5: return limit_shadow;
            6: return limit_shadow + 48'd1;
            7: return ADDR_MAX;
            default: return rand_addr();
        endcase
    endfunction

    function automatic rrt_req_t random_word();
        rrt_req_t w;
        int       k;
        int       pick;
        k             = $urandom_range(TABLE_DEPTH - 1);
        w.action      = ACT_REGISTER;
        w.name_given  = 1'($urandom_range(1));
        w.handler_id  = hid_t'($urandom);
        w.range_start = rand_addr();
        w.range_end   = rand_addr();
        w.probe_addr  = rand_addr();
        pick          = $urandom_range(99);
        if (pick < 40) begin
            w.name_given = ($urandom_range(9) != 0);
            case ($urandom_range(3))
                0: w.handler_id = '0;
                1: w.handler_id = slot_hid[k];
                default: begin
                end
            endcase
            case ($urandom_range(5))
                0: begin
                    w.range_start = '0;
                    w.range_end   = '0;
                end
                1: begin
                    w.range_start = slot_lo[k];
                    w.range_end   = slot_hi[k];
                end
                2: begin
                    w.range_start = near_addr();
                    w.range_end   = w.range_start + 48'd1 + addr_t'($urandom_range(4095));
                end
                3: begin
                    w.range_start = near_addr();
                    w.range_end   = w.range_start - addr_t'($urandom_range(4095));
                end
                4: begin
                    if ($urandom_range(1) == 0) w.range_start = '0;
                    else w.range_end = '0;
                end
                default: begin
                end
            endcase
        end else if (pick < 70) begin
            w.action     = ACT_CONTAINS;
            w.probe_addr = near_addr();
        end else if (pick < 95) begin
            w.action      = ACT_OVERLAP;
            w.range_start = near_addr();
            if ($urandom_range(3) == 0) w.range_end = near_addr();
            else w.range_end = w.range_start + addr_t'($urandom_range(8191));
        end else begin
            w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 17;
                recv_idle_pct = 84;
            end
            1: begin
                send_idle_pct = 84;
                recv_idle_pct = 17;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_word(input step_row_t row);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        fixed_answer_q.push_back(row);
        s_valid <= 1'b1;
        s_data  <= row.word;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input addr_t value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen      <= 1'b0;
        limit_shadow = value;
        n_settings++;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        rrt_rsp_t  want;
        step_row_t row;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_rsp_q.size() == 0) begin
                    $display("%0t: unexpected result word status %0d hit %0b", $time,
                             m_data.status, m_data.hit);
                    n_errors++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    n_results++;
                    if (m_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                                 want.status, m_data.status);
                        n_errors++;
                    end
                    if (m_data.hit !== want.hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b", $time,
                                 want.hit, m_data.hit);
                        n_errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                row  = fixed_answer_q.pop_front();
                want = resolve_request(s_data);
                if (row.known) want = row.rsp;
                pending_rsp_q.push_back(want);
                n_words++;
                if (want.hit) n_hits++;
                if (want.status == ST_INVALID) n_invalid++;
                if (want.status == ST_FULL) n_full++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_reserved_range_table_unit failed");
                $finish;
            end
        end
    end

    initial begin
        int        ph;
        int        n;
        step_row_t row;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_wdata    = '0;
        aresetn      = 1'b0;
        limit_shadow = LIMIT_RESET;
        idle_cycles  = 0;
        n_errors     = 0;
        n_words      = 0;
        n_results    = 0;
        n_hits       = 0;
        n_invalid    = 0;
        n_full       = 0;
        n_settings   = 1;
        for (n = 0; n < TABLE_DEPTH; n++) begin
            slot_hid[n] = '0;
            slot_lo[n]  = '0;
            slot_hi[n]  = '0;
        end
        set_idling(0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) send_word(directed_rows[i]);

        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: write_limit(ADDR_MAX);
                1: write_limit('0);
                2: write_limit(48'h1000);
                default: write_limit(rand_addr());
            endcase
            set_idling(ph);
            for (n = 0; n < PHASE_WORDS; n++) begin
                row.word  = random_word();
                row.known = 1'b0;
                row.rsp   = '0;
                send_word(row);
            end
        end
        drain();

        $display("Checked %0d result words for %0d request words under %0d task limits.",
                 n_results, n_words, n_settings);
        $display("Expected answers included %0d hits, %0d invalid and %0d full.",
                 n_hits, n_invalid, n_full);
        if (n_errors == 0) begin
            $display("tb_reserved_range_table_unit passed");
        end else begin
            $display("tb_reserved_range_table_unit failed");
        end
        $finish;
    end

endmodule
